FILE: rtl/core/sst_pkg.sv
package sst_pkg;

  // Default number of entries in the store
  localparam int CAPACITY_DEF = 64;

  // Reset value of the capacity limit register
  localparam logic [6:0] LIMIT_RESET = 7'd64;

  // Request kinds
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TEST   = 2'd2,
    KIND_POP    = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_MISS   = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Shift command broadcast to the cell row
  typedef enum logic [1:0] {
    SHIFT_HOLD = 2'd0,
    SHIFT_INS  = 2'd1,
    SHIFT_REM  = 2'd2
  } shift_t;

  // Broadcast to every cell: shift command and the request element
  typedef struct packed {
    shift_t      op;
    logic [31:0] elem;
  } cell_ctl_t;

  // Flip the sign bit so unsigned order matches signed order
  function automatic logic [31:0] order_key(input logic [31:0] v);
    order_key = {~v[31], v[30:0]};
  endfunction

endpackage

FILE: rtl/core/sst_cell.sv
module sst_cell (
  input  logic                clk,
  input  logic                rst,
  input  sst_pkg::cell_ctl_t  ctl,
  input  logic                occupied,
  input  logic                prev_lt,
  input  logic [31:0]         prev_value,
  input  logic [31:0]         next_value,
  output logic [31:0]         value,
  output logic                lt,
  output logic                eq
);
  import sst_pkg::*;

  logic [31:0] value_next;

  // Pick the new entry: keep, take the request element, or take from the lower neighbor or the upper one
  always_comb begin
    value_next = value;
    unique case (ctl.op)
      SHIFT_INS: begin
        if (!lt) value_next = prev_lt ? ctl.elem : prev_value;
      end
      SHIFT_REM: begin
        if (!lt) value_next = next_value;
      end
      SHIFT_HOLD: begin
        value_next = value;
      end
      default: begin
        value_next = value;
      end
    endcase
  end

  // Hold the entry
  always_ff @(posedge clk) begin
    value <= value_next;
  end

  // Register the compare against the request element
  always_ff @(posedge clk) begin
    if (rst) begin
      lt <= 1'b0;
      eq <= 1'b0;
    end else begin
      lt <= occupied && (order_key(value) < order_key(ctl.elem));
      eq <= occupied && (value == ctl.elem);
    end
  end

endmodule

FILE: rtl/core/sorted_set_table.sv
// Sorted set of distinct signed 32-bit values, held in ascending order in a
// row of cells. Requests arrive on the req channel (kind, element) and each
// gives exactly one beat on the rsp channel (status, position, value, count).
// A request beat is taken when req_valid is high and req_stall is low.
// The compare result of every cell is registered at the edge that takes the
// request; then, in the update state, the cells shift by one place for an
// insert or remove, the position and found flag are collected from the row
// and the response register is loaded, once the response register is free.
// A new request is not taken while one is in the update state: the compare
// step in the cells is followed by the shift and collect step.
// When the receiver stalls, the response beat holds unchanged; a finished
// request waits in the update state until the response register frees, and
// req_stall stays high meanwhile.
// Reset clears the element count, the response valid and sets the capacity
// limit register to 64. Entry contents are not cleared; entries at or beyond
// the count are never reported. The user writes the limit register (byte address 0)
// through the APB port only while no request is in flight; the block does not enforce it.
module sorted_set_table #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] element,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [1:0]         status,
  output logic [5:0]         position,
  output logic signed [31:0] value,
  output logic [6:0]         count
);
  import sst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = $clog2(CAPACITY);
  localparam int LW = (CW > 7) ? CW : 7;

  typedef enum logic {
    S_IDLE,
    S_UPD
  } state_t;

  state_t      state;
  logic [6:0]  capacity_limit;
  logic [CW-1:0] elem_count;
  logic [1:0]  req_kind;
  logic [31:0] req_elem;

  cell_ctl_t   ctl;
  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY-1:0] hit;
  logic [CAPACITY-1:0] top;
  logic [31:0] cell_value [CAPACITY];

  logic [PW-1:0] pos_enc;
  logic          found;
  logic [31:0]   pop_value;
  logic [LW-1:0] limit_eff;
  logic          full;
  logic          upd_go;

  shift_t        op_sel;
  logic [1:0]    status_next;
  logic [PW-1:0] pos_next;
  logic [31:0]   value_next;
  logic [CW-1:0] count_next;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'd0, capacity_limit} : 32'd0;

  assign req_stall = (state != S_IDLE);
  assign upd_go    = (state == S_UPD) && (!rsp_valid || !rsp_stall);

  // Broadcast compare element and shift command
  assign ctl.elem = (state == S_IDLE) ? element : req_elem;
  assign ctl.op   = upd_go ? op_sel : SHIFT_HOLD;

  // Mark cells that hold a live entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CW'(i) < elem_count);
    end
  end

  // Row of cells
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic        prev_lt;
    logic [31:0] prev_value;
    logic [31:0] next_value;
    if (g == 0) begin : g_first
      assign prev_lt    = 1'b1;
      assign prev_value = req_elem;
    end else begin : g_mid
      assign prev_lt    = lt_vec[g-1];
      assign prev_value = cell_value[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign next_value = cell_value[g];
    end else begin : g_inner
      assign next_value = cell_value[g+1];
    end
    sst_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .occupied   (occ[g]),
      .prev_lt    (prev_lt),
      .prev_value (prev_value),
      .next_value (next_value),
      .value      (cell_value[g]),
      .lt         (lt_vec[g]),
      .eq         (eq_vec[g])
    );
  end

  // Collect insertion point, found flag and the largest entry from the row
  always_comb begin
    pos_enc   = '0;
    pop_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit[i] = !lt_vec[i] && ((i == 0) ? 1'b1 : lt_vec[(i == 0) ? 0 : i - 1]);
      top[i] = occ[i] && ((i == CAPACITY - 1) ? 1'b1 : !occ[(i == CAPACITY - 1) ? i : i + 1]);
      if (hit[i]) pos_enc = pos_enc | PW'(i);
      if (top[i]) pop_value = pop_value | cell_value[i];
    end
    found = |(hit & eq_vec);
  end

  // Limit in force is the smaller of the register and the store size
  always_comb begin
    if (LW'(capacity_limit) < LW'(CAPACITY)) limit_eff = LW'(capacity_limit);
    else                                    limit_eff = LW'(CAPACITY);
    full = (LW'(elem_count) >= limit_eff);
  end

  // Decide the update and the response
  always_comb begin
    op_sel      = SHIFT_HOLD;
    status_next = ST_DONE;
    pos_next    = '0;
    value_next  = req_elem;
    count_next  = elem_count;
    unique case (kind_t'(req_kind))
      KIND_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else if (found) begin
          status_next = ST_MISS;
          pos_next    = pos_enc;
        end else begin
          op_sel     = SHIFT_INS;
          pos_next   = pos_enc;
          count_next = elem_count + CW'(1);
        end
      end
      KIND_REMOVE: begin
        if (found) begin
          op_sel     = SHIFT_REM;
          pos_next   = pos_enc;
          count_next = elem_count - CW'(1);
        end else begin
          status_next = ST_MISS;
        end
      end
      KIND_TEST: begin
        if (found) pos_next = pos_enc;
        else       status_next = ST_MISS;
      end
      KIND_POP: begin
        if (elem_count == '0) begin
          status_next = ST_EMPTY;
          value_next  = '0;
        end else begin
          count_next = elem_count - CW'(1);
          pos_next   = PW'(elem_count - CW'(1));
          value_next = pop_value;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  // State, count, limit register and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      elem_count     <= '0;
      capacity_limit <= LIMIT_RESET;
      rsp_valid      <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
        capacity_limit <= pwdata[6:0];
      end
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            req_kind <= kind;
            req_elem <= element;
            state    <= S_UPD;
          end
        end
        S_UPD: begin
          if (upd_go) begin
            elem_count <= count_next;
            rsp_valid  <= 1'b1;
            status     <= status_next;
            position   <= 6'(pos_next);
            value      <= value_next;
            count      <= 7'(count_next);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/sst_checker.sv
module sst_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_stall,
  input logic               rsp_valid,
  input logic               rsp_stall,
  input logic [1:0]         status,
  input logic [5:0]         position,
  input logic signed [31:0] value,
  input logic [6:0]         count
);
  import sst_pkg::*;

  // Empty pop reports zero value and an empty set
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_EMPTY) |-> (value == 32'sd0) && (count == 7'd0) && (position == 6'd0))
    else $error("empty pop beat carries data");

  // A refused insert reports no position
  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status == ST_FULL) |-> (position == 6'd0))
    else $error("full beat carries a position");

  // The block is busy in the cycle after it takes a request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken back to back");

  // A stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(value) && $stable(count))
    else $error("stalled response changed");

endmodule

bind sorted_set_table sst_checker u_sst_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .status    (status),
  .position  (position),
  .value     (value),
  .count     (count)
);

FILE: dv/sorted_set_table_test.sv
`timescale 1ns / 1ps

module sorted_set_table_test;
  import sst_pkg::*;

  localparam int         DEPTH      = CAPACITY_DEF;
  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  // First byte address past the register list
  localparam logic [2:0] ADDR_SPARE = 3'd4;
  localparam int         IDLE_PCT   = 21;
  localparam int         HOLD_LEN   = 300;
  localparam int         POOL_SIZE  = 80;

  typedef struct {
    kind_t       kind;
    logic [31:0] element;
  } req_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] value;
    logic [6:0]  count;
  } rsp_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         kind = KIND_INSERT;
  logic signed [31:0] element = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [1:0]         status;
  logic [5:0]         position;
  logic signed [31:0] value;
  logic [6:0]         count;

  sorted_set_table #(.CAPACITY(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .kind      (kind),
    .element   (element),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .position  (position),
    .value     (value),
    .count     (count)
  );

  // Shadow copy of the set and its limit register
  logic signed [31:0] set_vals [DEPTH];
  int unsigned        set_count = 0;
  logic [6:0]         limit_reg = LIMIT_RESET;

  req_item_t   pending_req [$];
  rsp_item_t   expected_rsp [$];
  logic [31:0] pool [POOL_SIZE];
  int          errors = 0;
  logic        req_beat = 1'b0;
  logic        steady = 1'b0;
  logic        hold_go = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Apply one request to the shadow set and return the response it gives
  function automatic rsp_item_t apply_request(kind_t k, logic signed [31:0] e);
    rsp_item_t   r;
    int unsigned lim;
    int unsigned below;
    logic        hit;
    below = 0;
    lim = (limit_reg < DEPTH) ? limit_reg : DEPTH;
    for (int i = 0; i < set_count; i++) begin
      if (set_vals[i] < e) below++;
    end
    hit = (below < set_count) && (set_vals[below] == e);
    r.status = ST_DONE;
    r.position = '0;
    r.value = e;
    case (k)
      KIND_INSERT: begin
        if (set_count + 1 > lim) begin
          r.status = ST_FULL;
        end else if (hit) begin
          r.status = ST_MISS;
          r.position = below[5:0];
        end else begin
          for (int i = set_count; i > below; i--) set_vals[i] = set_vals[i - 1];
          set_vals[below] = e;
          set_count++;
          r.position = below[5:0];
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (int i = below; i + 1 < set_count; i++) set_vals[i] = set_vals[i + 1];
          set_count--;
          r.position = below[5:0];
        end else begin
          r.status = ST_MISS;
        end
      end
      KIND_TEST: begin
        if (hit) r.position = below[5:0];
        else r.status = ST_MISS;
      end
      default: begin
        if (set_count == 0) begin
          r.status = ST_EMPTY;
          r.value = '0;
        end else begin
          set_count--;
          r.value = set_vals[set_count];
          r.position = set_count[5:0];
        end
      end
    endcase
    r.count = set_count[6:0];
    return r;
  endfunction

  // Request driver: hold a stalled beat, else offer the next pending item
  always @(negedge clk) begin
    req_item_t it;
    logic      next_valid;
    if (rst) begin
      next_valid = 1'b0;
    end else if (req_valid && !req_beat) begin
      next_valid = 1'b1;
    end else if (pending_req.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
      it = pending_req.pop_front();
      kind <= it.kind;
      element <= it.element;
      next_valid = 1'b1;
    end else begin
      next_valid = 1'b0;
    end
    req_valid <= next_valid;
  end

  // Response receiver: random stalls plus one long hold-off
  always @(negedge clk) begin
    int   hold_left;
    bit   hold_done;
    logic stall_next;
    if (hold_go && !hold_done) begin
      hold_left = HOLD_LEN;
      hold_done = 1'b1;
    end
    if (rst) begin
      stall_next = 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      stall_next = 1'b1;
    end else begin
      stall_next = !steady && ($urandom_range(99) < IDLE_PCT);
    end
    rsp_stall <= stall_next;
  end

  // Monitor: predict on each request beat, check each response beat
  always @(posedge clk) begin
    rsp_item_t want;
    req_beat = !rst && req_valid && !req_stall;
    if (req_beat) expected_rsp.push_back(apply_request(kind_t'(kind), element));
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response beat with nothing expected", value, 0);
      end else begin
        want = expected_rsp.pop_front();
        if (status !== want.status) report_mismatch("status", status, want.status);
        if (position !== want.position) report_mismatch("position", position, want.position);
        if (value !== want.value) report_mismatch("value", value, want.value);
        if (count !== want.count) report_mismatch("count", count, want.count);
      end
    end
  end

  task automatic wait_drained();
    while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write with setup and access cycles, only while drained
  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    wait_drained();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (addr == ADDR_LIMIT) limit_reg = data[6:0];
  endtask

  task automatic set_limit(logic [6:0] lim);
    logic [31:0] junk;
    junk = $urandom;
    apb_write(ADDR_LIMIT, {junk[31:7], lim});
  endtask

  task automatic queue_req(kind_t k, logic [31:0] e);
    req_item_t it;
    it.kind = k;
    it.element = e;
    pending_req.push_back(it);
  endtask

  // Random requests over a fresh value pool, weighted per phase
  task automatic queue_random(int n, int w_ins, int w_rem, int w_test);
    int          pick;
    logic [31:0] e;
    kind_t       k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      case ($urandom_range(3))
        0: pool[i] = $urandom_range(16) - 8;
        1: pool[i] = 32'h7fffffff - $urandom_range(3);
        2: pool[i] = 32'h80000000 + $urandom_range(3);
        default: pool[i] = $urandom;
      endcase
    end
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < w_ins) k = KIND_INSERT;
      else if (pick < w_ins + w_rem) k = KIND_REMOVE;
      else if (pick < w_ins + w_rem + w_test) k = KIND_TEST;
      else k = KIND_POP;
      pick = $urandom_range(99);
      if (pick < 60) e = pool[$urandom_range(POOL_SIZE - 1)];
      else if (pick < 70) e = $urandom_range(8) - 4;
      else e = $urandom;
      queue_req(k, e);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(posedge clk);

    // Directed: empty pop, misses, extremes, duplicates, full and zero limit
    queue_req(KIND_POP, 32'h0000_1234);
    queue_req(KIND_REMOVE, 32'd7);
    queue_req(KIND_TEST, 32'd7);
    queue_req(KIND_INSERT, 32'h7fffffff);
    queue_req(KIND_INSERT, 32'h80000000);
    queue_req(KIND_INSERT, 32'd0);
    queue_req(KIND_INSERT, 32'hffffffff);
    queue_req(KIND_INSERT, 32'd0);
    queue_req(KIND_TEST, 32'h80000000);
    queue_req(KIND_TEST, 32'd5);
    queue_req(KIND_REMOVE, 32'd5);
    queue_req(KIND_REMOVE, 32'hffffffff);
    queue_req(KIND_POP, 32'hffffffff);
    set_limit(7'd2);
    @(posedge clk);
    queue_req(KIND_INSERT, 32'd9);
    queue_req(KIND_INSERT, 32'd0);
    set_limit(7'd0);
    @(posedge clk);
    queue_req(KIND_INSERT, 32'd3);
    queue_req(KIND_POP, 32'd0);
    queue_req(KIND_POP, 32'd0);
    queue_req(KIND_POP, 32'd0);
    queue_req(KIND_REMOVE, 32'h80000000);
    queue_req(KIND_TEST, 32'h7fffffff);

    // Limit above the store size: fill to the top with no idling
    set_limit(7'd127);
    @(posedge clk);
    steady = 1'b1;
    queue_random(160, 70, 10, 10);
    wait_drained();
    @(posedge clk);
    steady = 1'b0;

    // Full limit, mixed traffic, receiver holds off while requests pile up
    set_limit(7'd64);
    @(posedge clk);
    queue_random(160, 35, 25, 25);
    repeat (10) @(posedge clk);
    hold_go = 1'b1;

    apb_write(ADDR_SPARE, $urandom);
    set_limit(7'($urandom_range(63, 2)));
    @(posedge clk);
    queue_random(120, 35, 25, 25);

    set_limit(7'd1);
    @(posedge clk);
    queue_random(60, 40, 20, 20);

    set_limit(7'd0);
    @(posedge clk);
    queue_random(40, 40, 20, 20);

    set_limit(7'd64);
    @(posedge clk);
    queue_random(160, 15, 35, 20);

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/sst_pkg.sv
rtl/core/sst_cell.sv
rtl/core/sorted_set_table.sv
rtl/core/sst_checker.sv
dv/sorted_set_table_test.sv
